// File: hdl/xsc_pkg.sv
package xsc_pkg;

  // ADC and scaling constants
  localparam int ADC_BITS    = 12;
  localparam int RESTART_BIN = 5;

  // defaults for the top level parameters
  localparam int MAX_POINTS_DEF     = 1024;
  localparam int PAIRS_PER_PASS_DEF = 1024;

  // width of the bin field in a work item (room for up to 4096 bins)
  localparam int BIN_MAX_W = 12;

  // register fields
  localparam int PC_W  = 11;
  localparam int SH_W  = 10;
  localparam int NP_W  = 8;
  localparam int VAL_W = 12;

  localparam logic [PC_W-1:0] POINT_COUNT_RST   = PC_W'(1024);
  localparam logic [SH_W-1:0] SCREEN_HEIGHT_RST = SH_W'(256);

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_COUNT   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = CFG_INDEX_W'(1);

  // front to back queue
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [11:0] sweep_sample;
    logic [11:0] level_sample;
    logic        load_norm;
    logic [7:0]  norm_passes;
  } pair_t;

  typedef struct packed {
    logic [9:0]         bin_index;
    logic signed [11:0] trace_value;
  } trace_t;

  // one trace write on its way to the back end
  typedef struct packed {
    logic [BIN_MAX_W-1:0]   bin;
    logic [SH_W-1:0]        lvl;
    logic signed [VAL_W-1:0] base_new;
    logic                   store;
  } work_t;

endpackage

// File: hdl/xsc_ram.sv
module xsc_ram #(
  parameter int Width = 12,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/xsc_queue.sv
module xsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xsc_pkg::work_t push_item,
  output logic          space,
  input  logic          pop,
  output xsc_pkg::work_t head,
  output logic          not_empty
);

  localparam int PtrW = $clog2(xsc_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(xsc_pkg::QUEUE_DEPTH + 1);

  xsc_pkg::work_t entries [xsc_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign space     = (count != CntW'(xsc_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && space;
  assign do_pop    = pop && not_empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PtrW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + PtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/xsc_front.sv
module xsc_front #(
  parameter int MaxPoints    = xsc_pkg::MAX_POINTS_DEF,
  parameter int PairsPerPass = xsc_pkg::PAIRS_PER_PASS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // sample pairs
  input  logic                             pair_valid,
  output logic                             pair_stall,
  input  xsc_pkg::pair_t                   pair,
  // configuration writes
  input  logic                             cfg_write,
  input  logic [xsc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [xsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  // back end busy clearing the baseline table
  input  logic                             clearing,
  // queue side
  output logic                             push,
  output xsc_pkg::work_t                   push_item,
  input  logic                             space
);

  localparam int BinW  = $clog2(MaxPoints);
  localparam int CntW  = $clog2(PairsPerPass);
  localparam int XpW   = xsc_pkg::ADC_BITS + xsc_pkg::PC_W;
  localparam int YpW   = xsc_pkg::ADC_BITS + xsc_pkg::SH_W;
  localparam int RawW  = xsc_pkg::BIN_MAX_W + 1;

  // configuration registers
  logic [xsc_pkg::PC_W-1:0] point_count;
  logic [xsc_pkg::SH_W-1:0] screen_height;

  // product stage
  logic                     p_valid;
  logic [XpW-1:0]           p_xprod;
  logic [YpW-1:0]           p_yprod;
  logic                     p_load;
  logic [xsc_pkg::NP_W-1:0] p_passes;

  // sweep state
  logic [BinW-1:0]          last_bin;
  logic [CntW-1:0]          pair_counter;
  logic [xsc_pkg::NP_W-1:0] norm_pending;

  // classification
  logic [RawW-1:0]          bin_raw;
  logic [BinW-1:0]          bin;
  logic [xsc_pkg::SH_W-1:0] lvl;
  logic [xsc_pkg::NP_W-1:0] pend;
  logic [BinW-1:0]          last_eff;
  logic                     emit;
  logic                     take;
  logic                     pass_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count   <= xsc_pkg::POINT_COUNT_RST;
      screen_height <= xsc_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        xsc_pkg::CFG_POINT_COUNT:   point_count   <= cfg_data[xsc_pkg::PC_W-1:0];
        xsc_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[xsc_pkg::SH_W-1:0];
        default: ;
      endcase
    end
  end

  // bin, level and the restart / advance decision
  always_comb begin
    bin_raw = RawW'(p_xprod[XpW-1:xsc_pkg::ADC_BITS]);
    if (bin_raw >= RawW'(MaxPoints)) begin
      bin = BinW'(MaxPoints - 1);
    end else begin
      bin = bin_raw[BinW-1:0];
    end
    lvl      = screen_height - p_yprod[YpW-1:xsc_pkg::ADC_BITS];
    pend     = p_load ? p_passes : norm_pending;
    last_eff = (bin < BinW'(xsc_pkg::RESTART_BIN)) ? '0 : last_bin;
    emit     = (bin > last_eff);
    pass_end = (pair_counter == CntW'(PairsPerPass - 1));
  end

  // a pair with no trace write never waits on the queue
  assign take       = p_valid && (space || !emit);
  assign pair_stall = clearing || (p_valid && !take);
  assign push       = take && emit;

  always_comb begin
    push_item          = '0;
    push_item.bin      = xsc_pkg::BIN_MAX_W'(bin);
    push_item.lvl      = lvl;
    push_item.base_new = $signed(xsc_pkg::VAL_W'(screen_height[xsc_pkg::SH_W-1:1]))
                       - $signed(xsc_pkg::VAL_W'(lvl));
    push_item.store    = (pend != '0);
  end

  // product stage: both scalings multiply here
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (pair_valid && !pair_stall) begin
      p_valid <= 1'b1;
    end else if (take) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_valid && !pair_stall) begin
      p_xprod  <= XpW'(pair.sweep_sample) * XpW'(point_count);
      p_yprod  <= YpW'(pair.level_sample) * YpW'(screen_height);
      p_load   <= pair.load_norm;
      p_passes <= pair.norm_passes;
    end
  end

  // sweep and normalization state, updated as each pair leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      last_bin     <= '0;
      pair_counter <= '0;
      norm_pending <= '0;
    end else if (take) begin
      last_bin <= emit ? bin : last_eff;
      if (pass_end) begin
        pair_counter <= '0;
        norm_pending <= (pend != '0) ? pend - xsc_pkg::NP_W'(1) : '0;
      end else begin
        pair_counter <= pair_counter + CntW'(1);
        norm_pending <= pend;
      end
    end
  end

endmodule

// File: hdl/xsc_back.sv
module xsc_back #(
  parameter int MaxPoints = xsc_pkg::MAX_POINTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  // queue side
  input  xsc_pkg::work_t head,
  input  logic           not_empty,
  output logic           pop,
  // baseline clear in progress
  output logic           clearing,
  // trace writes
  output logic           trace_valid,
  input  logic           trace_stall,
  output xsc_pkg::trace_t trace
);

  localparam int BinW = $clog2(MaxPoints);
  localparam int ValW = xsc_pkg::VAL_W;
  localparam int SumW = ValW + 1;

  // clearing pass
  logic [BinW-1:0] clr_addr;

  // table access
  logic            ram_we;
  logic [BinW-1:0] ram_waddr;
  logic [ValW-1:0] ram_wdata;
  logic [ValW-1:0] ram_rdata;

  // lookup stage
  logic                    r_valid;
  logic [9:0]              r_bin;
  logic [xsc_pkg::SH_W-1:0] r_lvl;
  logic signed [ValW-1:0]  r_base;
  logic                    r_store;
  logic                    r_move;
  logic signed [ValW-1:0]  base;
  logic signed [SumW-1:0]  sum;
  logic signed [ValW-1:0]  sum_sat;

  assign r_move = r_valid && (!trace_valid || !trace_stall);
  assign pop    = not_empty && !clearing && (!r_valid || r_move);

  // clear the baseline table once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + BinW'(1);
      if (clr_addr == BinW'(MaxPoints - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = pop && head.store;
      ram_waddr = head.bin[BinW-1:0];
      ram_wdata = head.base_new;
    end
  end

  xsc_ram #(
    .Width (ValW),
    .Depth (MaxPoints)
  ) u_baseline (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (head.bin[BinW-1:0]),
    .rdata (ram_rdata)
  );

  // lookup stage, aligned with the registered table read
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (pop) begin
      r_valid <= 1'b1;
    end else if (r_move) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_bin   <= head.bin[9:0];
      r_lvl   <= head.lvl;
      r_base  <= head.base_new;
      r_store <= head.store;
    end
  end

  // level plus baseline, saturated to 12 bits
  always_comb begin
    base = r_store ? r_base : $signed(ram_rdata);
    sum  = $signed(SumW'(r_lvl)) + SumW'(base);
    if (sum > $signed(SumW'(2047))) begin
      sum_sat = ValW'(2047);
    end else if (sum < -$signed(SumW'(2048))) begin
      sum_sat = -$signed(ValW'(2047)) - $signed(ValW'(1));
    end else begin
      sum_sat = sum[ValW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      trace_valid <= 1'b0;
    end else if (r_move) begin
      trace_valid <= 1'b1;
    end else if (!trace_stall) begin
      trace_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_move) begin
      trace.bin_index   <= r_bin;
      trace.trace_value <= sum_sat;
    end
  end

endmodule

// File: hdl/xy_sweep_trace_capture_unit.sv
// Sweep trace capture.
// A sample pair (sweep and level ADC codes plus a normalization load) transfers
// on the pair channel when pair_valid is high and pair_stall is low. Each pair
// is scaled to a trace bin and an inverted screen level; when the bin moves
// past the last bin written, one trace write (bin, level plus baseline) is
// offered on the trace channel, held until a cycle with trace_stall low.
// Registers (point count, screen height) are written on the cfg channel,
// which is always ready; write them only while the unit is idle.
// Throughput: one pair per cycle, unless clearing or a writing pair meets a
// full queue. Products are registered, then the pair is classified and
// queued, then the baseline table is read, then the sum is registered.
// A four-entry queue sits between classification and the table, so pairs
// that write nothing keep flowing while the trace receiver stalls; pairs
// that do write wait once the queue and output stages fill.
// Reset: a clearing pass zeroes all MaxPoints baseline entries (1024 by
// default) with pair_stall high; cfg writes are still taken.
module xy_sweep_trace_capture_unit #(
  parameter int MaxPoints    = xsc_pkg::MAX_POINTS_DEF,
  parameter int PairsPerPass = xsc_pkg::PAIRS_PER_PASS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pair_valid,
  output logic                            pair_stall,
  input  xsc_pkg::pair_t                  pair,
  output logic                            trace_valid,
  input  logic                            trace_stall,
  output xsc_pkg::trace_t                 trace,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [xsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [xsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic           clearing;
  logic           push;
  logic           space;
  logic           pop;
  logic           not_empty;
  xsc_pkg::work_t push_item;
  xsc_pkg::work_t head;

  assign cfg_ready = 1'b1;

  xsc_front #(
    .MaxPoints    (MaxPoints),
    .PairsPerPass (PairsPerPass)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair_stall (pair_stall),
    .pair       (pair),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clearing   (clearing),
    .push       (push),
    .push_item  (push_item),
    .space      (space)
  );

  xsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .space     (space),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  xsc_back #(
    .MaxPoints (MaxPoints)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .not_empty   (not_empty),
    .pop         (pop),
    .clearing    (clearing),
    .trace_valid (trace_valid),
    .trace_stall (trace_stall),
    .trace       (trace)
  );

endmodule
